@@ hdl/cmuv_pkg.sv @@
// ============================================================================
// cmuv_pkg
// Shared constants and types for the cube-map face and coordinate core.
// ============================================================================
`default_nettype none

package cmuv_pkg;

  // Direction component width and coordinate fraction bits
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 16;

  // Derived widths
  localparam int REM_W     = COORD_WIDTH + 1;  // partial remainder / doubled divisor
  localparam int QUO_W     = FRAC_BITS + 2;    // raw quotient, one rounding bit
  localparam int TEX_W     = FRAC_BITS + 1;    // Q0.FRAC_BITS including 1.0
  localparam int NUM_CELLS = QUO_W;            // one quotient bit per cell

  // Faces and their axis registers
  localparam int NUM_FACES = 6;
  localparam int AXES_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int FACE_W    = 3;

  typedef logic [NUM_FACES-1:0][AXES_W-1:0] axes_cfg_t;

  // Reset values, face 5 in the top slice
  localparam axes_cfg_t AXES_RESET = {6'd17, 6'd16, 6'd41, 6'd40, 6'd29, 6'd21};

  // Axis selector codes (bits 2..1 of an axis code; bit 0 is the sign)
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // One slot of the divider chain
  typedef struct packed {
    logic                 valid;
    logic                 degenerate;
    logic [FACE_W-1:0]    face;
    logic [REM_W-1:0]     div2;    // twice the major magnitude
    logic [REM_W-1:0]     rem_u;
    logic [REM_W-1:0]     rem_v;
    logic [QUO_W-1:0]     quo_u;
    logic [QUO_W-1:0]     quo_v;
  } cell_t;

endpackage

`default_nettype wire

@@ hdl/cmuv_front.sv @@
// ============================================================================
// cmuv_front
// Two-stage front end: major axis and face pick, then the numerators of the
// u and v ratios, loaded into the first slot of the divider chain.
// ============================================================================
`default_nettype none

module cmuv_front
  import cmuv_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  axes_cfg_t                     axes_i,
  output cell_t                         cell_o
);

  // Numerator s' = |m| + c * sign(m), always in [0, 2|m|]
  function automatic logic [REM_W-1:0] numer(
    input logic [2:0]                    code,
    input logic signed [COORD_WIDTH-1:0] dx,
    input logic signed [COORD_WIDTH-1:0] dy,
    input logic signed [COORD_WIDTH-1:0] dz,
    input logic                          neg,
    input logic [COORD_WIDTH-1:0]        m
  );
    logic signed [COORD_WIDTH-1:0] c;
    logic signed [COORD_WIDTH+1:0] e;
    logic signed [COORD_WIDTH+1:0] s;
    case (code[2:1])
      AXIS_X:  c = dx;
      AXIS_Y:  c = dy;
      AXIS_Z:  c = dz;
      default: c = '0;
    endcase
    e = (code[0] ^ neg) ? -((COORD_WIDTH+2)'(c)) : (COORD_WIDTH+2)'(c);
    s = e + $signed({2'b00, m});
    return s[REM_W-1:0];
  endfunction

  // Magnitudes
  logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_z;
  assign mag_x = dir_x_i[COORD_WIDTH-1] ? (~dir_x_i + 1'b1) : dir_x_i;
  assign mag_y = dir_y_i[COORD_WIDTH-1] ? (~dir_y_i + 1'b1) : dir_y_i;
  assign mag_z = dir_z_i[COORD_WIDTH-1] ? (~dir_z_i + 1'b1) : dir_z_i;

  // Major axis, ties go to x then y
  logic [1:0]             axis_xy, axis_sel;
  logic [COORD_WIDTH-1:0] mag_xy, mag_sel;
  logic                   neg_xy, neg_sel;
  always_comb begin
    if (mag_y > mag_x) begin
      axis_xy = AXIS_Y;
      mag_xy  = mag_y;
      neg_xy  = dir_y_i[COORD_WIDTH-1];
    end else begin
      axis_xy = AXIS_X;
      mag_xy  = mag_x;
      neg_xy  = dir_x_i[COORD_WIDTH-1];
    end
    if (mag_z > mag_xy) begin
      axis_sel = AXIS_Z;
      mag_sel  = mag_z;
      neg_sel  = dir_z_i[COORD_WIDTH-1];
    end else begin
      axis_sel = axis_xy;
      mag_sel  = mag_xy;
      neg_sel  = neg_xy;
    end
  end

  // Stage A registers
  logic                          a_valid_q;
  logic                          a_degen_q;
  logic                          a_neg_q;
  logic [FACE_W-1:0]             a_face_q;
  logic [COORD_WIDTH-1:0]        a_mag_q;
  logic signed [COORD_WIDTH-1:0] a_dx_q, a_dy_q, a_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      a_degen_q <= (mag_sel == '0);
      a_neg_q   <= neg_sel;
      a_face_q  <= {axis_sel, neg_sel};
      a_mag_q   <= mag_sel;
      a_dx_q    <= dir_x_i;
      a_dy_q    <= dir_y_i;
      a_dz_q    <= dir_z_i;
    end
  end

  // Stage B: face config lookup and numerators
  logic [AXES_W-1:0] face_cfg;
  assign face_cfg = axes_i[a_face_q];

  cell_t cell_d, cell_q;
  always_comb begin
    cell_d            = '0;
    cell_d.valid      = a_valid_q;
    cell_d.degenerate = a_degen_q;
    cell_d.face       = a_face_q;
    cell_d.div2       = {a_mag_q, 1'b0};
    cell_d.rem_u      = numer(face_cfg[2:0], a_dx_q, a_dy_q, a_dz_q, a_neg_q, a_mag_q);
    cell_d.rem_v      = numer(face_cfg[5:3], a_dx_q, a_dy_q, a_dz_q, a_neg_q, a_mag_q);
  end

  // Slot register: payload loads with a valid transaction, else only valid drops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (cell_d.valid) begin
      cell_q <= cell_d;
    end else begin
      cell_q.valid <= 1'b0;
    end
  end

  assign cell_o = cell_q;

  // Numerators never exceed twice the major magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_q.valid |-> (cell_q.rem_u <= cell_q.div2) && (cell_q.rem_v <= cell_q.div2))
    else $error("cmuv_front: numerator above twice the major magnitude");

  // A degenerate direction always comes from face zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && a_degen_q) |-> (a_face_q == '0))
    else $error("cmuv_front: degenerate direction with nonzero face");

endmodule

`default_nettype wire

@@ hdl/cmuv_cell.sv @@
// ============================================================================
// cmuv_cell
// One restoring-division cell: produces one quotient bit for u and for v
// and hands the doubled remainders to the next cell.
// ============================================================================
`default_nettype none

module cmuv_cell
  import cmuv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cell_t cell_i,
  output cell_t cell_o
);

  // Trial subtract of the doubled divisor, both lanes
  logic             ge_u, ge_v;
  logic [REM_W-1:0] keep_u, keep_v;
  assign ge_u   = (cell_i.rem_u >= cell_i.div2);
  assign ge_v   = (cell_i.rem_v >= cell_i.div2);
  assign keep_u = ge_u ? (cell_i.rem_u - cell_i.div2) : cell_i.rem_u;
  assign keep_v = ge_v ? (cell_i.rem_v - cell_i.div2) : cell_i.rem_v;

  cell_t cell_d, cell_q;
  always_comb begin
    cell_d       = cell_i;
    cell_d.rem_u = {keep_u[REM_W-2:0], 1'b0};
    cell_d.rem_v = {keep_v[REM_W-2:0], 1'b0};
    cell_d.quo_u = {cell_i.quo_u[QUO_W-2:0], ge_u};
    cell_d.quo_v = {cell_i.quo_v[QUO_W-2:0], ge_v};
  end

  // Slot register: payload loads with a valid transaction, else only valid drops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (cell_d.valid) begin
      cell_q <= cell_d;
    end else begin
      cell_q.valid <= 1'b0;
    end
  end

  assign cell_o = cell_q;

  // Doubled remainder stays below twice the doubled divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_q.valid && !cell_q.degenerate) |->
      ({1'b0, cell_q.rem_u} < {cell_q.div2, 1'b0}) &&
      ({1'b0, cell_q.rem_v} < {cell_q.div2, 1'b0}))
    else $error("cmuv_cell: remainder out of range");

endmodule

`default_nettype wire

@@ hdl/cube_map_face_and_uv_core.sv @@
// ============================================================================
// cube_map_face_and_uv_core
// Cube-map face selection and per-face u/v coordinates in Q0.16.
// ============================================================================
// Usage:
//   A direction (dir_x_i, dir_y_i, dir_z_i) is taken at a rising edge with
//   start_i high and busy_o low. busy_o stays low, so a new direction can be
//   issued every cycle; the core takes one transaction per clock.
//   Each result is shown for one cycle with result_valid_o high and must be
//   taken then; the receiver cannot stall the core, and none is needed.
//   Pipeline: two front-end stages (axis pick, numerators) and a chain of
//   FRAC_BITS + 2 division cells, one quotient bit per cell, u and v in
//   parallel lanes; rounding is done on the last cell's output.
//   Face axis registers are written on the cfg channel (cfg_ready_o is
//   always high); indexes above five are dropped. Write them only while no
//   transaction is in flight.
//   Reset clears the pipeline valid bits and loads the default face axes.
// ============================================================================
`default_nettype none

module cube_map_face_and_uv_core
  import cmuv_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // direction command
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  // result
  output logic                          result_valid_o,
  output logic [FACE_W-1:0]             face_index_o,
  output logic [TEX_W-1:0]              tex_u_o,
  output logic [TEX_W-1:0]              tex_v_o,
  output logic                          degenerate_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [AXES_W-1:0]             cfg_data_i
);

  // Face axis registers
  axes_cfg_t axes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axes_q <= AXES_RESET;
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i < CFG_IDX_W'(NUM_FACES))) begin
      axes_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // Front end and division chain
  cell_t chain [NUM_CELLS+1];

  cmuv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (start_i && !busy_o),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .axes_i  (axes_q),
    .cell_o  (chain[0])
  );

  for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
    cmuv_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[gi]),
      .cell_o (chain[gi+1])
    );
  end

  // Round half up: q = (Q + 1) >> 1
  cell_t            last;
  logic [QUO_W-1:0] sum_u, sum_v;
  assign last  = chain[NUM_CELLS];
  assign sum_u = last.quo_u + QUO_W'(1);
  assign sum_v = last.quo_v + QUO_W'(1);

  assign result_valid_o = last.valid;
  assign degenerate_o   = last.degenerate;
  assign face_index_o   = last.degenerate ? '0 : last.face;
  assign tex_u_o        = last.degenerate ? '0 : sum_u[QUO_W-1:1];
  assign tex_v_o        = last.degenerate ? '0 : sum_v[QUO_W-1:1];

  // Coordinates never pass 1.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (tex_u_o <= (TEX_W'(1) << FRAC_BITS)) &&
                       (tex_v_o <= (TEX_W'(1) << FRAC_BITS)))
    else $error("core: coordinate above one");

  // Face index is one of the six faces
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (face_index_o < FACE_W'(NUM_FACES)))
    else $error("core: face index out of range");

  // A valid first cell comes only from a valid front-end slot registered into it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[1].valid |-> $past(chain[0].valid))
    else $error("core: chain valid without source");

endmodule

`default_nettype wire

@@ bench/cmuv_checker.sv @@
// ----------------------------------------------------------------------------
// cmuv_checker
// Watches the direction, result and cfg channels of the cube-map core. It
// keeps a shadow copy of the face axis registers, predicts face and u/v for
// every accepted direction and compares each result with the oldest
// prediction in order.
// ----------------------------------------------------------------------------
module cmuv_checker
  import cmuv_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // direction command
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  // result
  input  logic                          result_valid_i,
  input  logic [FACE_W-1:0]             face_index_i,
  input  logic [TEX_W-1:0]              tex_u_i,
  input  logic [TEX_W-1:0]              tex_v_i,
  input  logic                          degenerate_i,
  // configuration
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [AXES_W-1:0]             cfg_data_i,
  // status to the bench top
  output int                            err_count_o,
  output int                            pending_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [TEX_W-1:0]  tex_u;
    logic [TEX_W-1:0]  tex_v;
    logic              degenerate;
  } face_uv_t;

  face_uv_t  face_uv_q[$];   // predictions waiting for their result
  axes_cfg_t face_axes;      // shadow of the face axis registers
  int        mismatches = 0;

  function automatic longint magnitude(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // Signed component named by a 3-bit axis code; codes past z read as zero
  function automatic longint axis_component(logic [2:0] code, longint cx, longint cy,
                                            longint cz);
    longint comp;
    case (code[2:1])
      AXIS_X:  comp = cx;
      AXIS_Y:  comp = cy;
      AXIS_Z:  comp = cz;
      default: comp = 0;
    endcase
    return code[0] ? -comp : comp;
  endfunction

  // (c + m) / (2m) in Q0.FRAC_BITS, half rounds up, clamped to 0..1.0
  function automatic logic [TEX_W-1:0] map_to_unit(longint c, longint m);
    longint s, am, num, den, q;
    s  = c + m;
    am = m;
    if (m < 0) begin
      s  = -s;
      am = -m;
    end
    if (s <= 0) return '0;
    num = s <<< FRAC_BITS;
    den = 2 * am;
    q   = (num + den / 2) / den;
    if (q > (longint'(1) <<< FRAC_BITS)) q = longint'(1) <<< FRAC_BITS;
    return q[TEX_W-1:0];
  endfunction

  function automatic face_uv_t predict_face_uv(axes_cfg_t axes,
                                               logic signed [COORD_WIDTH-1:0] dx,
                                               logic signed [COORD_WIDTH-1:0] dy,
                                               logic signed [COORD_WIDTH-1:0] dz);
    longint           cx, cy, cz, major;
    logic [1:0]       axis;
    logic [AXES_W-1:0] cfg;
    face_uv_t         r;
    cx = dx;
    cy = dy;
    cz = dz;
    // strict compares keep ties on x first, then y
    major = cx;
    axis  = AXIS_X;
    if (magnitude(cy) > magnitude(major)) begin
      major = cy;
      axis  = AXIS_Y;
    end
    if (magnitude(cz) > magnitude(major)) begin
      major = cz;
      axis  = AXIS_Z;
    end
    r = '0;
    if (major == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    r.face  = {axis, major < 0};
    cfg     = axes[r.face];
    r.tex_u = map_to_unit(axis_component(cfg[2:0], cx, cy, cz), major);
    r.tex_v = map_to_unit(axis_component(cfg[5:3], cx, cy, cz), major);
    return r;
  endfunction

  // Compare results, queue predictions, track register writes
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    face_uv_t want;
    if (!rst_ni) begin
      face_axes = AXES_RESET;
      face_uv_q.delete();
      err_count_o <= mismatches;
      pending_o   <= 0;
    end else begin
      if (result_valid_i) begin
        if (face_uv_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result face=%0d u=%0d v=%0d degen=%0b", $time,
                     face_index_i, tex_u_i, tex_v_i, degenerate_i);
        end else begin
          want = face_uv_q.pop_front();
          if (face_index_i !== want.face || tex_u_i !== want.tex_u ||
              tex_v_i !== want.tex_v || degenerate_i !== want.degenerate) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch exp face=%0d u=%0d v=%0d degen=%0b, got face=%0d u=%0d v=%0d degen=%0b",
                       $time, want.face, want.tex_u, want.tex_v, want.degenerate,
                       face_index_i, tex_u_i, tex_v_i, degenerate_i);
          end
        end
      end
      if (start_i && !busy_i)
        face_uv_q.push_back(predict_face_uv(face_axes, dir_x_i, dir_y_i, dir_z_i));
      // indexes past the last face are dropped by the core
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NUM_FACES)
        face_axes[cfg_index_i] = cfg_data_i;
      err_count_o <= mismatches;
      pending_o   <= face_uv_q.size();
    end
  end

endmodule

@@ bench/tb_cube_map_face_and_uv_core.sv @@
// ----------------------------------------------------------------------------
// tb_cube_map_face_and_uv_core
// Drives directions and face axis settings into the cube-map core. A short
// directed set hits a zero vector, full-scale and tie cases and all six faces;
// random directions follow under several register settings, with random
// gaps on both input channels. Checking is done by cmuv_checker.
// ----------------------------------------------------------------------------
module tb_cube_map_face_and_uv_core
  import cmuv_pkg::*;
();

  localparam int IDLE_PCT       = 28;
  localparam int RAND_PER_PHASE = 160;
  localparam int STEADY_FIRST   = 400;   // random transactions sent without gaps
  localparam int STEADY_LAST    = 560;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 3 * (FRAC_BITS + 3);

  // register slots the core does not implement
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

  typedef enum logic [2:0] {
    POS_X, NEG_X, POS_Y, NEG_Y, POS_Z, NEG_Z, ZERO_A, ZERO_B
  } axis_code_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  coord_t               dir_x_i, dir_y_i, dir_z_i;
  logic                 result_valid_o;
  logic [FACE_W-1:0]    face_index_o;
  logic [TEX_W-1:0]     tex_u_o, tex_v_o;
  logic                 degenerate_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [AXES_W-1:0]    cfg_data_i;

  int        fail_count;
  int        pending_count;
  int        stall_cycles = 0;
  int        rand_sent;
  bit        gaps_on;
  axes_cfg_t axes_mix;

  always #1 clk_i = ~clk_i;

  cube_map_face_and_uv_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .result_valid_o (result_valid_o),
    .face_index_o   (face_index_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .degenerate_o   (degenerate_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  cmuv_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .result_valid_i (result_valid_o),
    .face_index_i   (face_index_o),
    .tex_u_i        (tex_u_o),
    .tex_v_i        (tex_v_o),
    .degenerate_i   (degenerate_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .err_count_o    (fail_count),
    .pending_o      (pending_count)
  );

  // Watchdog: cycles without any transaction on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [AXES_W-1:0] axes_word(axis_code_e u, axis_code_e v);
    return {v, u};
  endfunction

  // Magnitude with a random sign; 32768 only exists as a negative value
  function automatic int with_sign(int m);
    if (m == 32768) return -32768;
    return $urandom_range(1) ? -m : m;
  endfunction

  function automatic int extreme_value(int k);
    case (k)
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [AXES_W-1:0] data);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write all six faces, then the unused slots, which must not alias a face
  task automatic load_axes(axes_cfg_t words);
    for (int f = 0; f < NUM_FACES; f++) write_cfg(CFG_IDX_W'(f), words[f]);
    write_cfg(CFG_IDX_SPARE_A, AXES_W'($urandom));
    write_cfg(CFG_IDX_SPARE_B, AXES_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_dir(int x, int y, int z);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    dir_x_i <= coord_t'(x);
    dir_y_i <= coord_t'(y);
    dir_z_i <= coord_t'(z);
    do @(posedge clk_i); while (busy_o);
  endtask

  // Stop issuing and wait until every predicted result has come back
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic pick_random_dir(output int x, output int y, output int z);
    int c[3];
    int kind, a, odd;
    kind = $urandom_range(99);
    for (int i = 0; i < 3; i++) c[i] = int'(coord_t'($urandom));
    if (kind < 35) begin
      // full range as drawn
    end else if (kind < 50) begin
      for (int i = 0; i < 3; i++) c[i] = int'($urandom_range(16)) - 8;
    end else if (kind < 68) begin
      // two or three equal magnitudes, the odd one smaller
      a   = $urandom_range(32768);
      odd = $urandom_range(3);
      for (int i = 0; i < 3; i++) begin
        if (i != odd) c[i] = with_sign(a);
        else c[i] = (a == 0) ? 0 : with_sign(int'($urandom_range(a - 1)));
      end
    end else if (kind < 80) begin
      for (int i = 0; i < 3; i++) c[i] = extreme_value($urandom_range(5));
    end else if (kind < 86) begin
      for (int i = 0; i < 3; i++) c[i] = 0;
      if ($urandom_range(1)) c[$urandom_range(2)] = int'(coord_t'($urandom));
    end else begin
      // one clearly dominant axis
      a = $urandom_range(2);
      for (int i = 0; i < 3; i++) c[i] = with_sign(int'($urandom_range(16383)));
      c[a] = with_sign(int'($urandom_range(32768, 16384)));
    end
    x = c[0];
    y = c[1];
    z = c[2];
  endtask

  task automatic run_random(int count);
    int x, y, z;
    repeat (count) begin
      gaps_on = !(rand_sent >= STEADY_FIRST && rand_sent < STEADY_LAST);
      pick_random_dir(x, y, z);
      send_dir(x, y, z);
      rand_sent++;
    end
    drain_results();
  endtask

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    dir_x_i     = '0;
    dir_y_i     = '0;
    dir_z_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    gaps_on     = 1'b1;
    rand_sent   = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed set under the reset face axes
    send_dir(0, 0, 0);
    send_dir(-32768, 0, 0);       send_dir(0, -32768, 0);      send_dir(0, 0, -32768);
    send_dir(32767, 32767, 32767); send_dir(-32768, -32768, -32768);
    send_dir(-32768, 32767, -32768);
    send_dir(5, -5, 0);           send_dir(0, -7, 7);          send_dir(-3, 1, 3);
    send_dir(7, -7, -7);
    send_dir(100, -50, 25);       send_dir(-100, 50, -25);
    send_dir(10, 200, -30);       send_dir(10, -200, -30);
    send_dir(1, 2, 3);            send_dir(-1, 2, -3);
    send_dir(1, 0, 0);            send_dir(-1, 0, 0);          send_dir(0, 0, 1);
    send_dir(32767, -32768, 1);   send_dir(3, 1, 2);
    drain_results();
    run_random(RAND_PER_PHASE);

    // every code +x, then every code zero
    load_axes('0);
    run_random(RAND_PER_PHASE);
    load_axes('1);
    run_random(RAND_PER_PHASE);

    // u on the face's own signed axis, v on the opposite sign
    for (int f = 0; f < NUM_FACES; f++)
      axes_mix[f] = axes_word(axis_code_e'(f), axis_code_e'(f ^ 1));
    load_axes(axes_mix);
    run_random(RAND_PER_PHASE);

    // one coordinate forced to the zero component on each face
    for (int f = 0; f < NUM_FACES; f++)
      axes_mix[f] = (f % 2 == 0) ? axes_word(ZERO_A, axis_code_e'($urandom_range(5)))
                                 : axes_word(axis_code_e'($urandom_range(5)), ZERO_A);
    load_axes(axes_mix);
    run_random(RAND_PER_PHASE);

    // fully random settings
    repeat (3) begin
      for (int f = 0; f < NUM_FACES; f++) axes_mix[f] = AXES_W'($urandom_range(63));
      load_axes(axes_mix);
      run_random(RAND_PER_PHASE);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
